[rtl/utf8c_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 classifier package
// Shared types, byte constants and helper functions for the UTF-8 stream
// encoding classifier.
// ----------------------------------------------------------------------------
package utf8c_pkg;

    // Result classes delivered at the end of a stream.
    typedef enum logic [1:0] {
        CLS_ASCII   = 2'd0,
        CLS_UTF8    = 2'd1,
        CLS_BOM     = 2'd2,
        CLS_UNKNOWN = 2'd3
    } enc_class_t;

    // Per-stream scan state.
    typedef struct packed {
        logic [1:0] byte_position;
        logic       bom_prefix_match;
        logic [1:0] pending_continuations;
        logic       saw_multibyte;
        logic       saw_error;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        byte_position:         2'd0,
        bom_prefix_match:      1'b1,
        pending_continuations: 2'd0,
        saw_multibyte:         1'b0,
        saw_error:             1'b0
    };

    localparam logic [1:0] BOM_LENGTH = 2'd3;

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    localparam logic [7:0] MASK_LEAD1 = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] MASK_CONT  = 8'hC0;

    localparam logic [7:0] PAT_LEAD1 = 8'h00;
    localparam logic [7:0] PAT_LEAD2 = 8'hC0;
    localparam logic [7:0] PAT_LEAD3 = 8'hE0;
    localparam logic [7:0] PAT_LEAD4 = 8'hF0;
    localparam logic [7:0] PAT_CONT  = 8'h80;

    // Expected byte of the byte order mark at a given position.
    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = BOM_BYTE0;
            2'd1:    b = BOM_BYTE1;
            2'd2:    b = BOM_BYTE2;
            default: b = BOM_BYTE0;
        endcase
        return b;
    endfunction

    // Sequence length opened by a lead byte, 1 to 4, or 0 when it is no lead byte.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        if ((b & MASK_LEAD1) == PAT_LEAD1) begin
            n = 3'd1;
        end
        else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            n = 3'd2;
        end
        else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            n = 3'd3;
        end
        else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            n = 3'd4;
        end
        else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage : utf8c_pkg
`default_nettype wire

[rtl/utf8c_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 classifier scan step
// Combinational update of the scan state for one request, and the class that
// the stream ends with when the request closes it.
// ----------------------------------------------------------------------------
module utf8c_step (
    input  var utf8c_pkg::scan_state_t state,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_only,
    input  wire logic                  last,
    output utf8c_pkg::scan_state_t     state_next,
    output utf8c_pkg::enc_class_t      encoding_class
);
    import utf8c_pkg::*;

    scan_state_t upd;
    logic [2:0]  n;

    assign n = lead_length(data_byte);

    always_comb
    begin
        upd = state;
        if (!end_only)
        begin
            if (state.byte_position < BOM_LENGTH)
            begin
                if (data_byte != bom_byte(state.byte_position))
                begin
                    upd.bom_prefix_match = 1'b0;
                end
                upd.byte_position = state.byte_position + 2'd1;
            end
            if (state.pending_continuations != 2'd0)
            begin
                if ((data_byte & MASK_CONT) == PAT_CONT)
                begin
                    upd.pending_continuations = state.pending_continuations - 2'd1;
                end
                else
                begin
                    // The offending byte is not retried as a lead byte.
                    upd.saw_error             = 1'b1;
                    upd.pending_continuations = 2'd0;
                end
            end
            else if (n == 3'd0)
            begin
                upd.saw_error = 1'b1;
            end
            else if (n > 3'd1)
            begin
                upd.saw_multibyte         = 1'b1;
                upd.pending_continuations = 2'(n - 3'd1);
            end
        end
    end

    always_comb
    begin
        if (upd.byte_position == BOM_LENGTH && upd.bom_prefix_match)
        begin
            encoding_class = CLS_BOM;
        end
        else if (upd.saw_error || upd.pending_continuations != 2'd0)
        begin
            encoding_class = CLS_UNKNOWN;
        end
        else if (upd.saw_multibyte)
        begin
            encoding_class = CLS_UTF8;
        end
        else
        begin
            encoding_class = CLS_ASCII;
        end
    end

    assign state_next = last ? SCAN_STATE_RESET : upd;

endmodule : utf8c_step
`default_nettype wire

[rtl/utf8_stream_encoding_classifier_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream encoding classifier
// Scans a byte stream and reports ASCII, UTF-8, UTF-8 with BOM or unknown at
// the request marked last.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while in_stall is low. Each
// request is captured in an input register; from there it updates the scan
// state, and for a request marked last the class is written to the result
// register, which drives encoding_class.
// in_stall rises only while the input register holds a last request and the
// result register is still held by out_stall. The scan state returns to its
// reset value after every stream end, so streams may follow back to back.
module utf8_stream_encoding_classifier_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_only,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      encoding_class
);
    import utf8c_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_only_reg;
    logic        s1_last_reg;
    logic        s1_advance;
    logic        out_free;

    scan_state_t state_reg;
    scan_state_t state_next;
    enc_class_t  step_class;

    logic        out_valid_reg;
    logic        out_valid_next;
    enc_class_t  out_class_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;

    assign s1_valid_next  = in_valid || (s1_valid_reg && !s1_advance);
    assign out_valid_next = (s1_advance && s1_last_reg) || (out_valid_reg && out_stall);

    utf8c_step u_step (
        .state          (state_reg),
        .data_byte      (s1_byte_reg),
        .end_only       (s1_end_only_reg),
        .last           (s1_last_reg),
        .state_next     (state_next),
        .encoding_class (step_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_byte_reg     <= data_byte;
            s1_end_only_reg <= end_only;
            s1_last_reg     <= last;
        end
        if (s1_advance && s1_last_reg)
        begin
            out_class_reg <= step_class;
        end
    end

    assign out_valid      = out_valid_reg;
    assign encoding_class = out_class_reg;

    // The input side is held back only by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_last_reg))
        else $error("input stalled without a pending result");

    // Closing a stream returns the scan state to its reset value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (state_reg == SCAN_STATE_RESET))
        else $error("scan state not cleared after stream end");

    // No byte taken yet means nothing recorded yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.byte_position == 2'd0) |->
            (state_reg.bom_prefix_match && !state_reg.saw_error &&
             !state_reg.saw_multibyte && state_reg.pending_continuations == 2'd0))
        else $error("scan state set before any byte");

    // A new result only follows a last request in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result without a stream end");

endmodule : utf8_stream_encoding_classifier_unit
`default_nettype wire

[dv/tb_utf8_stream_encoding_classifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 stream encoding classifier
// Feeds byte streams through the request channel with random gaps and
// receiver stalls. A scoreboard predicts the class of every stream and
// compares it with each delivered result, in order.
// ----------------------------------------------------------------------------
module tb_utf8_stream_encoding_classifier_unit;

    import utf8c_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned RANDOM_ITEMS   = 1000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       end_only;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] encoding_class;

    // Scan state of the stream in flight, as the scoreboard sees it.
    logic [1:0] bytes_seen;
    logic       bom_intact;
    logic [1:0] cont_owed;
    logic       multi_seen;
    logic       fault_seen;

    enc_class_t  expected_classes[$];
    logic [7:0]  stream_bytes[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned tx_gap_max     = 9;
    int unsigned rx_stall_max   = 9;
    int unsigned stall_left     = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;

    utf8_stream_encoding_classifier_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_only       (end_only),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .encoding_class (encoding_class)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------

    function automatic int unsigned utf8_seq_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    task automatic clear_scan_state();
        bytes_seen = 2'd0;
        bom_intact = 1'b1;
        cont_owed  = 2'd0;
        multi_seen = 1'b0;
        fault_seen = 1'b0;
    endtask

    // Advances the scan state by one accepted request and queues the class
    // that a request marked last must produce.
    task automatic classify_step(input logic [7:0] b, input logic eo, input logic lst);
        logic [7:0]  want;
        int unsigned len;
        enc_class_t  cls;
        if (!eo)
        begin
            if (bytes_seen != BOM_LENGTH)
            begin
                case (bytes_seen)
                    2'd0:    want = BOM_BYTE0;
                    2'd1:    want = BOM_BYTE1;
                    default: want = BOM_BYTE2;
                endcase
                if (b != want)
                begin
                    bom_intact = 1'b0;
                end
                bytes_seen = bytes_seen + 2'd1;
            end
            if (cont_owed != 2'd0)
            begin
                // A byte that breaks a sequence is not looked at again as a lead.
                if (b[7:6] == 2'b10)
                begin
                    cont_owed = cont_owed - 2'd1;
                end
                else
                begin
                    fault_seen = 1'b1;
                    cont_owed  = 2'd0;
                end
            end
            else
            begin
                len = utf8_seq_len(b);
                if (len == 0)
                begin
                    fault_seen = 1'b1;
                end
                else if (len > 1)
                begin
                    multi_seen = 1'b1;
                    cont_owed  = 2'(len - 1);
                end
            end
        end
        if (lst)
        begin
            if (bytes_seen == BOM_LENGTH && bom_intact)
            begin
                cls = CLS_BOM;
            end
            else if (fault_seen || cont_owed != 2'd0)
            begin
                cls = CLS_UNKNOWN;
            end
            else if (multi_seen)
            begin
                cls = CLS_UTF8;
            end
            else
            begin
                cls = CLS_ASCII;
            end
            expected_classes.push_back(cls);
            clear_scan_state();
        end
    endtask

    always @(posedge clk)
    begin
        enc_class_t exp_cls;
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = $urandom_range(0, rx_stall_max);
            if (expected_classes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result, encoding_class=%0d",
                             $realtime, encoding_class);
                end
            end
            else
            begin
                exp_cls = expected_classes.pop_front();
                if (encoding_class !== exp_cls)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: encoding_class expected %0d (%s), got %0d",
                                 $realtime, exp_cls, exp_cls.name(), encoding_class);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls after each result, plus an optional long hold.
    // ------------------------------------------------------------------------

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Entered and left at a falling edge. The request stays on the bus after
    // acceptance so that a following request with no gap replaces it directly.
    task automatic send_item(input logic [7:0] b, input logic eo, input logic lst);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        end_only  = eo;
        last      = lst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        classify_step(b, eo, lst);
        @(negedge clk);
    endtask

    task automatic send_stream_end();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_classes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_ascii_and_empty();
        send_stream_end();
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_multibyte_sequences();
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'hA9, 1'b0, 1'b1);
        send_item(8'hE2, 1'b0, 1'b0);
        send_item(8'h82, 1'b0, 1'b0);
        // An end-only request without last must leave the stream open.
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hAC, 1'b0, 1'b0);
        send_stream_end();
        send_item(8'hF0, 1'b0, 1'b0);
        send_item(8'h9F, 1'b0, 1'b0);
        send_item(8'h98, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_bom_prefix();
        // A faulty byte after the byte order mark must not change the class.
        send_item(BOM_BYTE0, 1'b0, 1'b0);
        send_item(BOM_BYTE1, 1'b0, 1'b0);
        send_item(BOM_BYTE2, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // Only part of the mark, which is also a cut-off sequence.
        send_item(BOM_BYTE0, 1'b0, 1'b0);
        send_item(BOM_BYTE1, 1'b0, 1'b0);
        send_stream_end();
        wait_drained();
    endtask

    task automatic test_error_cases();
        send_item(8'h80, 1'b0, 1'b1);
        send_item(8'hF8, 1'b0, 1'b1);
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h41, 1'b0, 1'b1);
        send_item(8'hE2, 1'b0, 1'b0);
        send_item(8'h82, 1'b0, 1'b0);
        send_stream_end();
        wait_drained();
    endtask

    task automatic test_back_pressure();
        int unsigned saved_tx;
        int unsigned saved_rx;
        saved_tx     = tx_gap_max;
        saved_rx     = rx_stall_max;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        hold_req     = 80;
        for (int i = 0; i < 12; i++)
        begin
            send_item(8'($urandom_range(0, 127)), 1'b0, 1'b1);
        end
        wait_drained();
        tx_gap_max   = saved_tx;
        rx_stall_max = saved_rx;
    endtask

    task automatic build_random_stream();
        int unsigned n_chars;
        int unsigned len;
        int unsigned mode;
        int unsigned pos;
        stream_bytes.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            stream_bytes.push_back(BOM_BYTE0);
            stream_bytes.push_back(BOM_BYTE1);
            stream_bytes.push_back(BOM_BYTE2);
        end
        n_chars = $urandom_range(0, 6);
        for (int c = 0; c < n_chars; c++)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1:       stream_bytes.push_back(8'($urandom_range(0, 127)));
                2:       stream_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                3:       stream_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                default: stream_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            for (int k = 1; k < len; k++)
            begin
                stream_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end
        // Half of the streams stay as built; the other half get a corrupted, dropped or
        // extra byte.
        mode = $urandom_range(0, 5);
        if (stream_bytes.size() != 0)
        begin
            pos = $urandom_range(0, stream_bytes.size() - 1);
            case (mode)
                0: stream_bytes[pos] = 8'($urandom_range(0, 255));
                1: void'(stream_bytes.pop_back());
                2: stream_bytes.insert(pos, 8'($urandom_range(0, 255)));
                default: ;
            endcase
        end
    endtask

    task automatic test_random_streams();
        int unsigned sent;
        logic        marker_end;
        logic        final_byte;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ((sent / 250) % 4)
                0:       begin tx_gap_max = 9; rx_stall_max = 9; end
                1:       begin tx_gap_max = 0; rx_stall_max = 0; end
                2:       begin tx_gap_max = 9; rx_stall_max = 0; end
                default: begin tx_gap_max = 0; rx_stall_max = 9; end
            endcase
            build_random_stream();
            marker_end = (stream_bytes.size() == 0) || ($urandom_range(0, 2) == 0);
            foreach (stream_bytes[i])
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                    sent++;
                end
                final_byte = (i == stream_bytes.size() - 1) && !marker_end;
                send_item(stream_bytes[i], 1'b0, final_byte);
            end
            if (marker_end)
            begin
                send_stream_end();
            end
            sent += stream_bytes.size() + (marker_end ? 1 : 0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        end_only  = 1'b0;
        last      = 1'b0;
        clear_scan_state();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ascii_and_empty();
        test_multibyte_sequences();
        test_bom_prefix();
        test_error_cases();
        test_back_pressure();
        test_random_streams();

        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/utf8c_pkg.sv
rtl/utf8c_step.sv
rtl/utf8_stream_encoding_classifier_unit.sv
dv/tb_utf8_stream_encoding_classifier_unit.sv
